[sv/frp_pkg.sv]
package frp_pkg;

  // cordic datapath: sign, guard bits and 40 fraction bits
  localparam int XY_W = 43;
  localparam int XY_FRAC = 40;

  typedef logic signed [XY_W-1:0] xy_t;

  // inverse cordic gain in q40
  localparam xy_t INV_GAIN = 43'sd667681663043;

  // pi in q60, used to turn radians into turns
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // number of polarization lanes: ll, rr, lr, rl
  localparam int LANES = 4;

  typedef enum logic [1:0] {
    MOUNT_NONE  = 2'd0,
    MOUNT_CASS  = 2'd1,
    MOUNT_NAS_L = 2'd2,
    MOUNT_NAS_R = 2'd3
  } mount_t;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  // station angle: parallactic angle plus mount factor times elevation
  function automatic logic [31:0] station_angle(logic [31:0] par, logic [31:0] el,
                                                mount_t mount);
    logic [31:0] a;
    a = par;
    unique case (mount)
      MOUNT_NONE:  a = par;
      MOUNT_CASS:  a = par;
      MOUNT_NAS_L: a = par - el;
      MOUNT_NAS_R: a = par + el;
    endcase
    return a;
  endfunction

  // atan(2^-i) for i >= 1 in units of 2^-64 turn, elaboration only
  function automatic logic [63:0] atan_turn64(int unsigned i);
    longint      acc;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
    logic [63:0] qt;
    logic [63:0] r2;
    int unsigned p;
    int unsigned top;
    acc = 0;
    for (int unsigned k = 0; k < 64; k++) begin
      p = i * (2 * k + 1);
      if (p <= 62) begin
        // floor(2^(62-p) / (2k+1)) by shift and subtract
        dvs = 64'(2 * k + 1);
        top = 62 - p;
        r2 = '0;
        qt = '0;
        for (int b = 62; b >= 0; b--) begin
          r2 = (r2 << 1) | 64'(b == int'(top));
          qt = qt << 1;
          if (r2 >= dvs) begin
            r2 = r2 - dvs;
            qt = qt | 64'd1;
          end
        end
        if (k[0]) acc = acc - longint'(qt);
        else acc = acc + longint'(qt);
      end
    end
    // radians to turns: times 2/pi by long division
    rem = 64'(acc);
    quo = '0;
    for (int unsigned n = 0; n < 61; n++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= PI_Q60) begin
        rem = rem - PI_Q60;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // rotation table entry rounded to ab bits per turn
  function automatic logic [63:0] atan_entry(int unsigned i, int unsigned ab);
    logic [63:0] t64;
    logic [63:0] half;
    t64 = (i == 0) ? (64'd1 << 61) : atan_turn64(i);
    half = 64'd1 << (63 - ab);
    return (t64 + half) >> (64 - ab);
  endfunction

endpackage

[sv/frp_if.sv]
interface frp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] par_angle_ref;
  logic [31:0] par_angle_rem;
  logic [31:0] elevation_ref;
  logic [31:0] elevation_rem;
  logic [1:0]  mount_ref;
  logic [1:0]  mount_rem;

  modport source (
    output valid, par_angle_ref, par_angle_rem, elevation_ref, elevation_rem,
           mount_ref, mount_rem,
    input  ready
  );
  modport sink (
    input  valid, par_angle_ref, par_angle_rem, elevation_ref, elevation_rem,
           mount_ref, mount_rem,
    output ready
  );
endinterface

interface frp_out_if #(
  parameter int OUT_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] ll_re;
  logic signed [OUT_BITS-1:0] ll_im;
  logic signed [OUT_BITS-1:0] rr_re;
  logic signed [OUT_BITS-1:0] rr_im;
  logic signed [OUT_BITS-1:0] lr_re;
  logic signed [OUT_BITS-1:0] lr_im;
  logic signed [OUT_BITS-1:0] rl_re;
  logic signed [OUT_BITS-1:0] rl_im;

  modport source (
    output valid, ll_re, ll_im, rr_re, rr_im, lr_re, lr_im, rl_re, rl_im,
    input  ready
  );
  modport sink (
    input  valid, ll_re, ll_im, rr_re, rr_im, lr_re, lr_im, rl_re, rl_im,
    output ready
  );
endinterface

[sv/frp_rot_stage.sv]
module frp_rot_stage #(
  parameter int ANGLE_BITS = 32,
  parameter int STAGE = 0,
  parameter logic [ANGLE_BITS-1:0] ATAN = '0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  frp_pkg::xy_t          x_i [frp_pkg::LANES],
  input  frp_pkg::xy_t          y_i [frp_pkg::LANES],
  input  logic [ANGLE_BITS-1:0] z_i [frp_pkg::LANES],
  input  frp_pkg::quad_t        q_i [frp_pkg::LANES],
  output logic                  vld_o,
  output frp_pkg::xy_t          x_o [frp_pkg::LANES],
  output frp_pkg::xy_t          y_o [frp_pkg::LANES],
  output logic [ANGLE_BITS-1:0] z_o [frp_pkg::LANES],
  output frp_pkg::quad_t        q_o [frp_pkg::LANES]
);

  logic                  vld_r;
  frp_pkg::xy_t          x_r   [frp_pkg::LANES];
  frp_pkg::xy_t          y_r   [frp_pkg::LANES];
  logic [ANGLE_BITS-1:0] z_r   [frp_pkg::LANES];
  frp_pkg::quad_t        q_r   [frp_pkg::LANES];
  frp_pkg::xy_t          x_nxt [frp_pkg::LANES];
  frp_pkg::xy_t          y_nxt [frp_pkg::LANES];
  logic [ANGLE_BITS-1:0] z_nxt [frp_pkg::LANES];

  // one micro-rotation per lane, direction from the sign of z
  always_comb begin
    frp_pkg::xy_t dx;
    frp_pkg::xy_t dy;
    for (int l = 0; l < frp_pkg::LANES; l++) begin
      dx = y_i[l] >>> STAGE;
      dy = x_i[l] >>> STAGE;
      if (!z_i[l][ANGLE_BITS-1]) begin
        x_nxt[l] = x_i[l] - dx;
        y_nxt[l] = y_i[l] + dy;
        z_nxt[l] = z_i[l] - ATAN;
      end else begin
        x_nxt[l] = x_i[l] + dx;
        y_nxt[l] = y_i[l] - dy;
        z_nxt[l] = z_i[l] + ATAN;
      end
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      q_r <= q_i;
    end
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign q_o   = q_r;

endmodule

[sv/field_rotation_phasors.sv]
// channel   dir  handshake      payload
// in_ch     in   valid/ready    par_angle_ref/rem, elevation_ref/rem, mount_ref/rem
// out_ch    out  valid/ready    ll, rr, lr, rl phasors (re, im), OUT_BITS each
//
// one baseline per cycle while the output is not stalled; the core is an
// unrolled cordic (one register stage per micro-rotation, four lanes wide)
// reset clears the stage valid bits only
// a stage holds when the next one is full and stalled, so bubbles are
// squeezed out and input is still taken while a result waits at the output
module field_rotation_phasors #(
  parameter int ANGLE_BITS = 32,
  parameter int OUT_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  frp_in_if.sink    in_ch,
  frp_out_if.source out_ch
);

  localparam int LANES = frp_pkg::LANES;
  localparam int XY_W = frp_pkg::XY_W;
  // stages: angles, combos, quadrant, cordic, quadrant fix, output
  localparam int NS = CORDIC_STAGES + 5;
  localparam int S_FIX = CORDIC_STAGES + 3;
  localparam int S_OUT = CORDIC_STAGES + 4;
  localparam int SHR = frp_pkg::XY_FRAC + 1 - OUT_BITS;
  localparam logic signed [XY_W:0] RND = (XY_W + 1)'(64'sd1 <<< (SHR - 1));
  localparam logic signed [XY_W:0] Q_HI = (XY_W + 1)'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [XY_W:0] Q_LO = -Q_HI - (XY_W + 1)'(1);

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // stall chain: a stage moves when it is empty or the next one moves
  genvar gk;
  generate
    for (gk = 0; gk < NS - 1; gk++) begin : g_en
      assign en[gk] = !vld[gk] || en[gk+1];
    end
  endgenerate
  assign en[NS-1] = !vld[NS-1] || out_ch.ready;
  assign in_ch.ready = en[0];

  // ---------------- station angles
  logic        s1_vld_r;
  logic [31:0] a0_r;
  logic [31:0] a1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en[0]) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_r <= frp_pkg::station_angle(in_ch.par_angle_ref, in_ch.elevation_ref,
                                     frp_pkg::mount_t'(in_ch.mount_ref));
      a1_r <= frp_pkg::station_angle(in_ch.par_angle_rem, in_ch.elevation_rem,
                                     frp_pkg::mount_t'(in_ch.mount_rem));
    end
  end
  assign vld[0] = s1_vld_r;

  // ---------------- polarization combinations, cut or extended to ANGLE_BITS
  logic [31:0]           comb [LANES];
  logic [ANGLE_BITS-1:0] theta_nxt [LANES];
  logic [ANGLE_BITS-1:0] theta_r [LANES];
  logic                  s2_vld_r;

  always_comb begin
    comb[0] = a0_r - a1_r;
    comb[1] = a1_r - a0_r;
    comb[2] = a0_r + a1_r;
    comb[3] = ~(a0_r + a1_r) + 32'd1;
  end

  generate
    if (ANGLE_BITS <= 32) begin : g_cut
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          theta_nxt[l] = comb[l][31 -: ANGLE_BITS];
        end
      end
    end else begin : g_ext
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          theta_nxt[l] = {comb[l], {(ANGLE_BITS - 32){1'b0}}};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en[1]) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      theta_r <= theta_nxt;
    end
  end
  assign vld[1] = s2_vld_r;

  // ---------------- negate, split into quadrant and residual
  logic [ANGLE_BITS-1:0] z3_nxt [LANES];
  frp_pkg::quad_t        q3_nxt [LANES];
  logic [ANGLE_BITS-1:0] z3_r [LANES];
  frp_pkg::quad_t        q3_r [LANES];
  logic                  s3_vld_r;

  always_comb begin
    logic [ANGLE_BITS-1:0] phi;
    logic [ANGLE_BITS-1:0] phs;
    logic [1:0]            qb;
    for (int l = 0; l < LANES; l++) begin
      phi = ~theta_r[l] + ANGLE_BITS'(1);
      phs = phi + (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
      qb = phs[ANGLE_BITS-1 -: 2];
      q3_nxt[l] = frp_pkg::quad_t'(qb);
      z3_nxt[l] = {phi[ANGLE_BITS-1 -: 2] - qb, phi[ANGLE_BITS-3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en[2]) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      z3_r <= z3_nxt;
      q3_r <= q3_nxt;
    end
  end
  assign vld[2] = s3_vld_r;

  // ---------------- cordic pipeline
  frp_pkg::xy_t          x_s [CORDIC_STAGES+1][LANES];
  frp_pkg::xy_t          y_s [CORDIC_STAGES+1][LANES];
  logic [ANGLE_BITS-1:0] z_s [CORDIC_STAGES+1][LANES];
  frp_pkg::quad_t        q_s [CORDIC_STAGES+1][LANES];
  logic [CORDIC_STAGES:0] cv;

  // cordic seed: x at the inverse gain, y at zero
  genvar gl;
  generate
    for (gl = 0; gl < LANES; gl++) begin : g_seed
      assign x_s[0][gl] = frp_pkg::INV_GAIN;
      assign y_s[0][gl] = '0;
    end
  endgenerate
  assign z_s[0] = z3_r;
  assign q_s[0] = q3_r;
  assign cv[0]  = s3_vld_r;

  genvar gi;
  generate
    for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
      localparam logic [ANGLE_BITS-1:0] ATAN =
        ANGLE_BITS'(frp_pkg::atan_entry(gi, ANGLE_BITS));
      frp_rot_stage #(
        .ANGLE_BITS(ANGLE_BITS),
        .STAGE(gi),
        .ATAN(ATAN)
      ) u_rot (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en[gi+3]),
        .vld_i (cv[gi]),
        .x_i   (x_s[gi]),
        .y_i   (y_s[gi]),
        .z_i   (z_s[gi]),
        .q_i   (q_s[gi]),
        .vld_o (cv[gi+1]),
        .x_o   (x_s[gi+1]),
        .y_o   (y_s[gi+1]),
        .z_o   (z_s[gi+1]),
        .q_o   (q_s[gi+1])
      );
      assign vld[gi+3] = cv[gi+1];
    end
  endgenerate

  // ---------------- quadrant fix
  frp_pkg::xy_t xo_nxt [LANES];
  frp_pkg::xy_t yo_nxt [LANES];
  frp_pkg::xy_t xo_r [LANES];
  frp_pkg::xy_t yo_r [LANES];
  logic         fix_vld_r;

  always_comb begin
    frp_pkg::xy_t xc;
    frp_pkg::xy_t yc;
    for (int l = 0; l < LANES; l++) begin
      xc = x_s[CORDIC_STAGES][l];
      yc = y_s[CORDIC_STAGES][l];
      case (q_s[CORDIC_STAGES][l])
        frp_pkg::QUAD_0: begin
          xo_nxt[l] = xc;
          yo_nxt[l] = yc;
        end
        frp_pkg::QUAD_90: begin
          xo_nxt[l] = -yc;
          yo_nxt[l] = xc;
        end
        frp_pkg::QUAD_180: begin
          xo_nxt[l] = -xc;
          yo_nxt[l] = -yc;
        end
        default: begin
          xo_nxt[l] = yc;
          yo_nxt[l] = -xc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_vld_r <= 1'b0;
    end else if (en[S_FIX]) begin
      fix_vld_r <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_FIX]) begin
      xo_r <= xo_nxt;
      yo_r <= yo_nxt;
    end
  end
  assign vld[S_FIX] = fix_vld_r;

  // ---------------- round, saturate, output register
  function automatic logic [OUT_BITS-1:0] quant(frp_pkg::xy_t v);
    logic signed [XY_W:0] s;
    logic signed [XY_W:0] sh;
    s  = (XY_W + 1)'(v) + RND;
    sh = s >>> SHR;
    if (sh > Q_HI) return Q_HI[OUT_BITS-1:0];
    else if (sh < Q_LO) return Q_LO[OUT_BITS-1:0];
    else return sh[OUT_BITS-1:0];
  endfunction

  logic [OUT_BITS-1:0] re_r [LANES];
  logic [OUT_BITS-1:0] im_r [LANES];
  logic                out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en[S_OUT]) begin
      out_vld_r <= fix_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      for (int l = 0; l < LANES; l++) begin
        re_r[l] <= quant(xo_r[l]);
        im_r[l] <= quant(yo_r[l]);
      end
    end
  end
  assign vld[S_OUT] = out_vld_r;

  assign out_ch.valid = out_vld_r;
  assign out_ch.ll_re = re_r[0];
  assign out_ch.ll_im = im_r[0];
  assign out_ch.rr_re = re_r[1];
  assign out_ch.rr_im = im_r[1];
  assign out_ch.lr_re = re_r[2];
  assign out_ch.lr_im = im_r[2];
  assign out_ch.rl_re = re_r[3];
  assign out_ch.rl_im = im_r[3];

endmodule

[dv/tb_field_rotation_phasors.sv]
module tb_field_rotation_phasors;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_BITS = 32;
  localparam int OUT_BITS = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int PIPE_LATENCY = CORDIC_STAGES + 5;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [31:0]      par_ref;
    logic [31:0]      par_rem;
    logic [31:0]      el_ref;
    logic [31:0]      el_rem;
    frp_pkg::mount_t  mnt_ref;
    frp_pkg::mount_t  mnt_rem;
  } baseline_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] re;
    logic signed [OUT_BITS-1:0] im;
  } phasor_t;

  // lane order: ll, rr, lr, rl
  typedef phasor_t [0:frp_pkg::LANES-1] phasor_set_t;

  logic clk;
  logic rst_n;

  frp_in_if in_ch ();
  frp_out_if #(.OUT_BITS(OUT_BITS)) out_ch ();

  field_rotation_phasors #(
    .ANGLE_BITS(ANGLE_BITS),
    .OUT_BITS(OUT_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  longint      atan_units [CORDIC_STAGES];
  phasor_set_t pending_phasors [$];
  string       lane_name [frp_pkg::LANES] = '{"ll", "rr", "lr", "rl"};
  int          errors;
  int          stall_cycles;
  int          sink_hold;
  bit          idle_on;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // rotation step angles: atan(2^-i) in units of 2^-32 turn, rounded half up
  function automatic longint atan_step(int i);
    longint      acc;
    logic [63:0] term;
    logic [63:0] rem;
    logic [63:0] quo;
    int          p;
    if (i == 0) return longint'(1) << (ANGLE_BITS - 3);
    acc = 0;
    for (int k = 0; k < 64; k++) begin
      p = i * (2 * k + 1);
      if (p <= 62) begin
        term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
        acc = k[0] ? acc - longint'(term) : acc + longint'(term);
      end
    end
    // radians to turns: multiply by 2/pi through restoring division
    rem = 64'(acc);
    quo = '0;
    for (int n = 0; n < 61; n++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= frp_pkg::PI_Q60) begin
        rem = rem - frp_pkg::PI_Q60;
        quo = quo | 64'd1;
      end
    end
    return longint'((quo + (64'd1 << (63 - ANGLE_BITS))) >> (64 - ANGLE_BITS));
  endfunction

  // per-station angle with mount correction, wraps modulo a full turn
  function automatic logic [31:0] baseline_angle(logic [31:0] par, logic [31:0] el,
                                                 frp_pkg::mount_t mnt);
    case (mnt)
      frp_pkg::MOUNT_NAS_L: return par - el;
      frp_pkg::MOUNT_NAS_R: return par + el;
      default:              return par;
    endcase
  endfunction

  // round q40 to output width and clamp
  function automatic logic signed [OUT_BITS-1:0] to_fixed(longint v);
    longint t;
    t = (v + (longint'(1) << (40 - OUT_BITS))) >>> (41 - OUT_BITS);
    if (t > (longint'(1) << (OUT_BITS - 1)) - 1) t = (longint'(1) << (OUT_BITS - 1)) - 1;
    if (t < -(longint'(1) << (OUT_BITS - 1))) t = -(longint'(1) << (OUT_BITS - 1));
    return t[OUT_BITS-1:0];
  endfunction

  // exp(-i*a) by quadrant fold plus rotation-mode cordic
  function automatic phasor_t rotate_phasor(logic [31:0] a);
    logic [31:0]     phi;
    logic [31:0]     folded;
    logic [31:0]     resid;
    frp_pkg::quad_t  q;
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    longint          xo;
    longint          yo;
    phasor_t         p;
    phi = 32'd0 - a;
    folded = phi + 32'h2000_0000;
    q = frp_pkg::quad_t'(folded[31:30]);
    resid = phi - {folded[31:30], 30'd0};
    z = $signed(resid);
    x = longint'(frp_pkg::INV_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_units[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_units[i];
      end
    end
    case (q)
      frp_pkg::QUAD_0:   begin xo = x;  yo = y;  end
      frp_pkg::QUAD_90:  begin xo = -y; yo = x;  end
      frp_pkg::QUAD_180: begin xo = -x; yo = -y; end
      default:           begin xo = y;  yo = -x; end
    endcase
    p.re = to_fixed(xo);
    p.im = to_fixed(yo);
    return p;
  endfunction

  function automatic phasor_set_t predict_phasors(baseline_t b);
    logic [31:0] a_ref;
    logic [31:0] a_rem;
    phasor_set_t s;
    a_ref = baseline_angle(b.par_ref, b.el_ref, b.mnt_ref);
    a_rem = baseline_angle(b.par_rem, b.el_rem, b.mnt_rem);
    s[0] = rotate_phasor(a_ref - a_rem);
    s[1] = rotate_phasor(a_rem - a_ref);
    s[2] = rotate_phasor(a_ref + a_rem);
    s[3] = rotate_phasor(32'd0 - a_ref - a_rem);
    return s;
  endfunction

  // angle within a few units of an octant boundary
  function automatic logic [31:0] near_octant();
    logic [31:0] base;
    base = {3'($urandom_range(0, 7)), 29'd0};
    return base + 32'($urandom_range(0, 15)) - 32'd8;
  endfunction

  function automatic baseline_t random_baseline();
    baseline_t b;
    b.par_ref = $urandom;
    b.par_rem = $urandom;
    b.el_ref = $urandom;
    b.el_rem = $urandom;
    b.mnt_ref = frp_pkg::mount_t'($urandom_range(0, 3));
    b.mnt_rem = frp_pkg::mount_t'($urandom_range(0, 3));
    return b;
  endfunction

  // send one baseline beat, with an optional idle burst before it
  task automatic send_baseline(baseline_t b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.par_angle_ref <= b.par_ref;
    in_ch.par_angle_rem <= b.par_rem;
    in_ch.elevation_ref <= b.el_ref;
    in_ch.elevation_rem <= b.el_rem;
    in_ch.mount_ref <= b.mnt_ref;
    in_ch.mount_rem <= b.mnt_rem;
    do @(posedge clk); while (!in_ch.ready);
    pending_phasors.push_back(predict_phasors(b));
    @(negedge clk);
  endtask

  task automatic send_fields(logic [31:0] par_ref, logic [31:0] par_rem,
                             logic [31:0] el_ref, logic [31:0] el_rem,
                             frp_pkg::mount_t mnt_ref, frp_pkg::mount_t mnt_rem);
    baseline_t b;
    b = '{par_ref, par_rem, el_ref, el_rem, mnt_ref, mnt_rem};
    send_baseline(b);
  endtask

  // stop sending and hold until every predicted beat has come back
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (pending_phasors.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reset_dut();
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
  endtask

  // extremes, every mount code, saturation and quadrant boundaries
  task automatic test_directed();
    send_fields(32'h0, 32'h0, 32'h0, 32'h0, frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'h0, 32'h0, 32'h1234_5678, 32'h8765_4321,
                frp_pkg::MOUNT_CASS, frp_pkg::MOUNT_CASS);
    send_fields(32'h1000_0000, 32'h0, 32'h0800_0000, 32'h0400_0000,
                frp_pkg::MOUNT_NAS_L, frp_pkg::MOUNT_NAS_R);
    send_fields(32'h1000_0000, 32'h0, 32'h0800_0000, 32'h0400_0000,
                frp_pkg::MOUNT_NAS_R, frp_pkg::MOUNT_NAS_L);
    send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_CASS);
    send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                frp_pkg::MOUNT_NAS_R, frp_pkg::MOUNT_NAS_R);
    send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                frp_pkg::MOUNT_NAS_L, frp_pkg::MOUNT_NAS_L);
    send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                frp_pkg::MOUNT_NAS_R, frp_pkg::MOUNT_NAS_L);
    send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                frp_pkg::MOUNT_NAS_L, frp_pkg::MOUNT_NAS_R);
    send_fields(32'h4000_0000, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'h8000_0000, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'hC000_0000, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_CASS, frp_pkg::MOUNT_NONE);
    send_fields(32'h2000_0000, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'h1FFF_FFFF, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'h6000_0000, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'h5FFF_FFFF, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'hA000_0000, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'hE000_0000, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'hDFFF_FFFF, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'h0000_0001, 32'h0, 32'h0, 32'h0,
                frp_pkg::MOUNT_NONE, frp_pkg::MOUNT_NONE);
    send_fields(32'h0, 32'h0, 32'h2000_0000, 32'hE000_0000,
                frp_pkg::MOUNT_NAS_R, frp_pkg::MOUNT_NAS_R);
  endtask

  task automatic test_random_baselines(int n);
    for (int i = 0; i < n; i++) send_baseline(random_baseline());
  endtask

  // combined angles close to octant and quadrant boundaries
  task automatic test_octant_edges(int n);
    baseline_t b;
    for (int i = 0; i < n; i++) begin
      b.par_ref = near_octant();
      b.par_rem = $urandom_range(0, 1) ? 32'h0 : near_octant();
      b.el_ref = near_octant();
      b.el_rem = near_octant();
      b.mnt_ref = frp_pkg::mount_t'($urandom_range(0, 3));
      b.mnt_rem = frp_pkg::mount_t'($urandom_range(0, 3));
      send_baseline(b);
    end
  endtask

  // bursts separated by a full drain of the pipeline
  task automatic test_drain_pause(int rounds, int burst);
    for (int r = 0; r < rounds; r++) begin
      for (int i = 0; i < burst; i++) send_baseline(random_baseline());
      wait_results_drained();
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_back_to_back(int n);
    idle_on = 1'b0;
    for (int i = 0; i < n; i++) send_baseline(random_baseline());
  endtask

  // result sink: random stall bursts
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_hold <= $urandom_range(1, 19) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    phasor_set_t want;
    phasor_set_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got[0] = '{out_ch.ll_re, out_ch.ll_im};
      got[1] = '{out_ch.rr_re, out_ch.rr_im};
      got[2] = '{out_ch.lr_re, out_ch.lr_im};
      got[3] = '{out_ch.rl_re, out_ch.rl_im};
      if (pending_phasors.size() == 0) begin
        errors++;
        $display("%0t: result beat with no prediction pending", $time);
      end else begin
        want = pending_phasors.pop_front();
        for (int l = 0; l < frp_pkg::LANES; l++) begin
          if (got[l].re !== want[l].re) begin
            errors++;
            $display("%0t: %s_re mismatch, expected %0d, got %0d", $time, lane_name[l],
                     want[l].re, got[l].re);
          end
          if (got[l].im !== want[l].im) begin
            errors++;
            $display("%0t: %s_im mismatch, expected %0d, got %0d", $time, lane_name[l],
                     want[l].im, got[l].im);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("field_rotation_phasors verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.par_angle_ref = '0;
    in_ch.par_angle_rem = '0;
    in_ch.elevation_ref = '0;
    in_ch.elevation_rem = '0;
    in_ch.mount_ref = frp_pkg::MOUNT_NONE;
    in_ch.mount_rem = frp_pkg::MOUNT_NONE;
    out_ch.ready = 1'b0;
    errors = 0;
    stall_cycles = 0;
    sink_hold = 0;
    idle_on = 1'b1;
    for (int i = 0; i < CORDIC_STAGES; i++) atan_units[i] = atan_step(i);

    reset_dut();
    test_directed();
    test_random_baselines(850);
    test_octant_edges(400);
    test_drain_pause(5, 40);
    test_back_to_back(400);

    wait_results_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("field_rotation_phasors verification clean");
    end else begin
      $display("field_rotation_phasors verification failed");
    end
    $finish;
  end

endmodule
